### src/psd_pkg.sv
package psd_pkg;

    localparam int DIST_W = 17;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

### src/point_segment_distance.sv
// Throughput: one request per cycle; busy is always low, nothing stalls.
// The path is a pure pipeline: one divider stage per quotient bit and one
// square root stage per result bit, so depth grows with COORD_BITS.
// Reset (rst_n, async, active low) clears all stage valid bits and done;
// requests in flight are dropped. The receiver cannot stall.
module point_segment_distance #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    output logic                          done,
    output logic [psd_pkg::DIST_W-1:0]    distance
);
    import psd_pkg::*;

    localparam int N   = COORD_BITS;
    localparam int DFW = N + 1;
    localparam int PW  = 2 * N + 2;
    localparam int SW  = 2 * N + 4;
    localparam int MW  = 2 * N + 3;
    localparam int K   = N + 2;
    localparam int HW  = MW - K;
    localparam int NW  = 2 * MW;
    localparam int Q   = 2 * N + 4;
    localparam int EW  = 2 * N + 3;
    localparam int RB  = N + 2;
    localparam int RW  = N + 3;

    assign busy = 1'b0;

    // stage 1: differences
    logic                  v1_reg;
    logic signed [DFW-1:0] ax1_reg, ay1_reg, dx1_reg, dy1_reg, bx1_reg, by1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ax1_reg <= $signed({point_x[N-1], point_x}) - $signed({start_x[N-1], start_x});
        ay1_reg <= $signed({point_y[N-1], point_y}) - $signed({start_y[N-1], start_y});
        dx1_reg <= $signed({end_x[N-1], end_x}) - $signed({start_x[N-1], start_x});
        dy1_reg <= $signed({end_y[N-1], end_y}) - $signed({start_y[N-1], start_y});
        bx1_reg <= $signed({point_x[N-1], point_x}) - $signed({end_x[N-1], end_x});
        by1_reg <= $signed({point_y[N-1], point_y}) - $signed({end_y[N-1], end_y});
    end

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] axdx2_reg, aydy2_reg, dxdx2_reg, dydy2_reg;
    logic signed [PW-1:0] axdy2_reg, aydx2_reg, axax2_reg, ayay2_reg, bxbx2_reg, byby2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        axdx2_reg <= ax1_reg * dx1_reg;
        aydy2_reg <= ay1_reg * dy1_reg;
        dxdx2_reg <= dx1_reg * dx1_reg;
        dydy2_reg <= dy1_reg * dy1_reg;
        axdy2_reg <= ax1_reg * dy1_reg;
        aydx2_reg <= ay1_reg * dx1_reg;
        axax2_reg <= ax1_reg * ax1_reg;
        ayay2_reg <= ay1_reg * ay1_reg;
        bxbx2_reg <= bx1_reg * bx1_reg;
        byby2_reg <= by1_reg * by1_reg;
    end

    // stage 3: sums
    logic                 v3_reg;
    logic signed [SW-1:0] dot3_reg, len3_reg, cross3_reg, sqa3_reg, sqb3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dot3_reg   <= SW'(axdx2_reg) + SW'(aydy2_reg);
        len3_reg   <= SW'(dxdx2_reg) + SW'(dydy2_reg);
        cross3_reg <= SW'(axdy2_reg) - SW'(aydx2_reg);
        sqa3_reg   <= SW'(axax2_reg) + SW'(ayay2_reg);
        sqb3_reg   <= SW'(bxbx2_reg) + SW'(byby2_reg);
    end

    // stage 4: region select, |cross|
    logic          v4_reg, cr4_reg;
    logic [MW-1:0] mag4_reg, sq4_reg;
    logic [EW-1:0] den4_reg;
    logic          dot_pos, dot_ge;

    assign dot_pos = !dot3_reg[SW-1] && (dot3_reg != '0);
    assign dot_ge  = dot3_reg >= len3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cr4_reg  <= dot_pos && !dot_ge;
        mag4_reg <= cross3_reg[SW-1] ? MW'(-cross3_reg) : MW'(cross3_reg);
        sq4_reg  <= dot_pos ? MW'(sqb3_reg) : MW'(sqa3_reg);
        den4_reg <= EW'(len3_reg);
    end

    // stage 5: partial products of |cross|^2
    logic            v5_reg, cr5_reg;
    logic [2*HW-1:0] hh5_reg;
    logic [HW+K-1:0] hl5_reg;
    logic [2*K-1:0]  ll5_reg;
    logic [MW-1:0]   sq5_reg;
    logic [EW-1:0]   den5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hh5_reg  <= mag4_reg[MW-1:K] * mag4_reg[MW-1:K];
        hl5_reg  <= mag4_reg[MW-1:K] * mag4_reg[K-1:0];
        ll5_reg  <= mag4_reg[K-1:0] * mag4_reg[K-1:0];
        cr5_reg  <= cr4_reg;
        sq5_reg  <= sq4_reg;
        den5_reg <= den4_reg;
    end

    // stage 6 and divider: quotient = floor(num / den), one bit per stage
    logic          dv_reg   [0:Q];
    logic [EW-1:0] drem_reg [0:Q];
    logic [Q-1:0]  dlo_reg  [0:Q];
    logic [EW-1:0] dden_reg [0:Q];
    logic [NW-1:0] num6;

    assign num6 = cr5_reg ? (NW'(hh5_reg) << (2 * K)) + (NW'(hl5_reg) << (K + 1))
                          + NW'(ll5_reg)
                          : NW'(sq5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg[0] <= EW'(num6[NW-1:Q]);
        dlo_reg[0]  <= num6[Q-1:0];
        dden_reg[0] <= cr5_reg ? den5_reg : EW'(1);
    end

    for (genvar s = 0; s < Q; s++)
    begin : g_div
        logic [EW:0] trial;
        logic        ge;

        assign trial = {drem_reg[s], dlo_reg[s][Q-1]};
        assign ge    = trial >= {1'b0, dden_reg[s]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s+1] <= 1'b0;
            end
            else
            begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            drem_reg[s+1] <= ge ? EW'(trial - {1'b0, dden_reg[s]}) : EW'(trial);
            dlo_reg[s+1]  <= {dlo_reg[s][Q-2:0], ge};
            dden_reg[s+1] <= dden_reg[s];
        end
    end

    // square root, one result bit per stage
    logic          sv_reg    [0:RB];
    logic [RW-1:0] srem_reg  [0:RB];
    logic [RB-1:0] sroot_reg [0:RB];
    logic [Q-1:0]  sval_reg  [0:RB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= dv_reg[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        srem_reg[0]  <= '0;
        sroot_reg[0] <= '0;
        sval_reg[0]  <= dlo_reg[Q];
    end

    for (genvar s = 0; s < RB; s++)
    begin : g_sqrt
        logic [RW+1:0] trial;
        logic [RW+1:0] sub;
        logic          ge;

        assign trial = {srem_reg[s], sval_reg[s][Q-1:Q-2]};
        assign sub   = (RW+2)'({sroot_reg[s], 2'b01});
        assign ge    = trial >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[s+1] <= 1'b0;
            end
            else
            begin
                sv_reg[s+1] <= sv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            srem_reg[s+1]  <= ge ? RW'(trial - sub) : RW'(trial);
            sroot_reg[s+1] <= {sroot_reg[s][RB-2:0], ge};
            sval_reg[s+1]  <= {sval_reg[s][Q-3:0], 2'b00};
        end
    end

    // output with saturation
    logic [DIST_W+RB-1:0] root_ext;
    logic                 sat;
    logic [DIST_W-1:0]    distance_reg;
    logic                 done_reg;

    assign root_ext = {{DIST_W{1'b0}}, sroot_reg[RB]};
    assign sat      = |root_ext[DIST_W+RB-1:DIST_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sv_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= sat ? DIST_MAX : root_ext[DIST_W-1:0];
    end

    assign done     = done_reg;
    assign distance = distance_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(sv_reg[RB]))
        else $error("done without a finished root");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[Q] |-> (drem_reg[Q] < dden_reg[Q]))
        else $error("divider remainder not below divisor");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg[RB] |-> ((RB+1)'(srem_reg[RB]) <= {sroot_reg[RB], 1'b0}))
        else $error("root remainder out of bound");

endmodule

### sim/point_segment_distance_tb.sv
module point_segment_distance_tb;

    import psd_pkg::*;

    localparam int CW = 16;
    localparam int LATENCY = 3 * CW + 13;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } query_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] point_x, point_y, start_x, start_y, end_x, end_y;
    logic                 done;
    logic [DIST_W-1:0]    distance;

    query_t            pending_queries[$];
    logic [DIST_W-1:0] expected_dist[$];
    int                errors = 0;
    int                matched = 0;
    longint            cycles;
    bit                stim_done;
    bit                hold_off;
    int                burst_left;
    int                gap_left;

    point_segment_distance #(.COORD_BITS(CW)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y),
        .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .done(done), .distance(distance)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Largest d with d*d*den <= num.
    function automatic logic [DIST_W-1:0] floor_root_ratio(logic [127:0] num,
                                                           logic [63:0] den);
        logic [63:0]  d;
        logic [63:0]  c;
        logic [127:0] prod;
        d = 0;
        for (int b = 26; b >= 0; b--)
        begin
            c = d | (64'd1 << b);
            prod = 128'(c * c) * 128'(den);
            if (prod <= num)
                d = c;
        end
        if (d > 64'(DIST_MAX))
            d = 64'(DIST_MAX);
        return d[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] seg_distance(query_t q);
        longint ax, ay, dx, dy, dot, len2, cr, bx, by;
        ax = longint'(q.px) - longint'(q.sx);
        ay = longint'(q.py) - longint'(q.sy);
        dx = longint'(q.ex) - longint'(q.sx);
        dy = longint'(q.ey) - longint'(q.sy);
        dot = ax * dx + ay * dy;
        len2 = dx * dx + dy * dy;
        if (dot <= 0)
            return floor_root_ratio(128'(ax * ax + ay * ay), 64'd1);
        if (dot >= len2)
        begin
            bx = longint'(q.px) - longint'(q.ex);
            by = longint'(q.py) - longint'(q.ey);
            return floor_root_ratio(128'(bx * bx + by * by), 64'd1);
        end
        cr = ax * dy - ay * dx;
        if (cr < 0)
            cr = -cr;
        return floor_root_ratio(128'(cr) * 128'(cr), 64'(len2));
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff - 16'($urandom_range(0, 3));
            1: return 16'sh8000 + 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_query(input int a, input int b, input int c,
                             input int d, input int e, input int f);
        query_t q;
        q.px = a[CW-1:0];
        q.py = b[CW-1:0];
        q.sx = c[CW-1:0];
        q.sy = d[CW-1:0];
        q.ex = e[CW-1:0];
        q.ey = f[CW-1:0];
        pending_queries.push_back(q);
    endtask

    task automatic add_random_query();
        query_t q;
        int     k;
        q.px = rand_coord();
        q.py = rand_coord();
        q.sx = rand_coord();
        q.sy = rand_coord();
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            q.ex = q.sx;
            q.ey = q.sy;
        end
        else if (k < 3)
        begin
            // collinear with the segment, possibly past either end
            q.ex = q.sx + 16'($urandom_range(0, 200)) - 16'sd100;
            q.ey = q.sy + 16'($urandom_range(0, 200)) - 16'sd100;
            q.px = q.sx + (q.ex - q.sx) * (16'($urandom_range(0, 6)) - 16'sd2);
            q.py = q.sy + (q.ey - q.sy) * (16'($urandom_range(0, 6)) - 16'sd2);
        end
        else
        begin
            q.ex = rand_coord();
            q.ey = rand_coord();
        end
        pending_queries.push_back(q);
    endtask

    initial
    begin
        stim_done = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        add_query(0, 0, 0, 0, 0, 0);
        add_query(32767, 32767, -32768, -32768, -32768, -32768);
        add_query(-32768, -32768, 32767, 32767, 32767, 32767);
        add_query(32767, -32768, -32768, 32767, -32768, 32767);
        add_query(-32768, 32767, -32768, -32768, 32767, 32767);
        add_query(32767, -32768, -32768, -32768, 32767, 32767);
        add_query(-32768, -32768, -32768, 32767, 32767, -32768);
        add_query(0, 100, -100, 0, 100, 0);
        add_query(0, -100, -100, 0, 100, 0);
        add_query(-200, 0, -100, 0, 100, 0);
        add_query(200, 0, -100, 0, 100, 0);
        add_query(50, 0, -100, 0, 100, 0);
        add_query(-100, 5, -100, 0, 100, 0);
        add_query(100, 5, -100, 0, 100, 0);
        add_query(3, 4, 0, 0, 0, 0);
        add_query(-1, -1, 0, 0, 1, 1);
        add_query(7, 3, 1, 1, 2, 9);
        add_query(32767, 32767, 32767, 32767, 32767, 32767);
        add_query(-32768, 0, 32767, -32768, 32767, 32767);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_queries.size() == 0);
        hold_off = 1'b1;
        wait (!start && expected_dist.size() == 0);
        hold_off = 1'b0;
        repeat (400) add_random_query();
        stim_done = 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            {point_x, point_y, start_x, start_y, end_x, end_y} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_dist.push_back(seg_distance(
                    {point_x, point_y, start_x, start_y, end_x, end_y}));
            if (start && busy)
                ;
            else if (gap_left > 0 || hold_off || pending_queries.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                query_t q;
                q = pending_queries.pop_front();
                start <= 1'b1;
                {point_x, point_y, start_x, start_y, end_x, end_y} <= q;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_dist.size() == 0)
            begin
                $display("%0t: unexpected result, actual distance=%0d", $time, distance);
                errors++;
            end
            else
            begin
                logic [DIST_W-1:0] want;
                want = expected_dist.pop_front();
                if (distance !== want)
                begin
                    $display("%0t: distance mismatch expected=%0d actual=%0d",
                             $time, want, distance);
                    errors++;
                end
                else
                    matched++;
            end
        end
    end

    initial
    begin
        cycles = 0;
        wait (stim_done);
        while ((pending_queries.size() != 0 || start || expected_dist.size() != 0)
               && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_dist.size());
            $display("Verification failed");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 10) @(posedge clk);
            $display("Checked %0d distance results: directed extremes, degenerate", matched);
            $display("and collinear segments, random coordinates with bursty requests");
            if (errors == 0 && expected_dist.size() == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        #(20 * CYCLE_LIMIT * 2);
        $display("Verification failed");
        $finish;
    end

endmodule
